[hdl/mpq_pkg.sv]
`timescale 1ns / 1ps
// Shared types and codes for the max-priority queue core.
// No dependencies; imported by every module of the block.
package mpq_pkg;

   localparam int VALUE_W = 32;

   typedef enum logic [1:0] {
      OP_CLEAR   = 2'd0,
      OP_INSERT  = 2'd1,
      OP_EXTRACT = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT
   } state_type;

   typedef struct packed {
      logic [1:0]                op;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] out_value;
      logic [1:0]                status;
      logic                      is_empty;
      logic                      is_full;
   } rsp_type;

endpackage

[hdl/max_priority_queue_core.sv]
`timescale 1ns / 1ps
// Max-priority queue of signed 32-bit values over an entry store.
// Depends on mpq_pkg and mpq_mem.
//
// Usage:
//   req channel: one word carries op (clear, insert, extract max) and value.
//   rsp channel: one word per request with out_value, status, is_empty and
//   is_full, the flags reporting the queue after the operation.
//   Clear, insert and unused op codes answer in the cycle after acceptance.
//   Extract on a queue of N entries scans the store one entry per cycle
//   through one signed comparator, then closes the gap one entry per cycle
//   through the single store port pair, from the oldest maximum upward;
//   its answer is registered when the close-up reaches the last entry.
//   req_ready is low while an extract is in progress. The response sits in
//   an output register; a new request is taken while it is being taken,
//   and a stalled receiver holds the block in idle until the word drains.
//   Reset empties the queue; entry contents are left as they are.
module max_priority_queue_core #(
   parameter int DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mpq_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mpq_pkg::rsp_type  rsp_data
);
   import mpq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   state_type                 state_ff, state_in;
   logic [CW-1:0]             occ_ff, occ_in;
   logic [AW-1:0]             idx_ff, idx_in;
   logic [AW-1:0]             best_idx_ff, best_idx_in;
   logic signed [VALUE_W-1:0] best_val_ff, best_val_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic signed [VALUE_W-1:0] wr_data;
   logic [AW-1:0]             rd_addr;
   logic signed [VALUE_W-1:0] rd_data;

   logic [CW-1:0]             occ_dec;
   logic                      scan_hit;
   logic                      at_last;
   logic [AW-1:0]             best_idx_nx;
   logic signed [VALUE_W-1:0] best_val_nx;

   mpq_mem #(
      .DEPTH (DEPTH)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign occ_dec     = occ_ff - CW'(1);
   assign at_last     = (CW'(idx_ff) == occ_dec);
   // strict compare keeps the oldest of equal values
   assign scan_hit    = (idx_ff == '0) || (rd_data > best_val_ff);
   assign best_idx_nx = scan_hit ? idx_ff : best_idx_ff;
   assign best_val_nx = scan_hit ? rd_data : best_val_ff;

   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      idx_in       = idx_ff;
      best_idx_in  = best_idx_ff;
      best_val_in  = best_val_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      req_ready    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = rd_data;
      rd_addr      = '0;

      case (state_ff)
         S_IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            if (req_valid && req_ready) begin
               rsp_in.out_value = '0;
               rsp_in.status    = ST_OK;
               rsp_in.is_empty  = (occ_ff == '0);
               rsp_in.is_full   = (occ_ff == CW'(DEPTH));
               case (req_data.op)
                  OP_CLEAR: begin
                     occ_in          = '0;
                     rsp_in.is_empty = 1'b1;
                     rsp_in.is_full  = 1'b0;
                     rsp_valid_in    = 1'b1;
                  end
                  OP_INSERT: begin
                     if (occ_ff == CW'(DEPTH)) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        wr_en           = 1'b1;
                        wr_addr         = occ_ff[AW-1:0];
                        wr_data         = req_data.value;
                        occ_in          = occ_ff + CW'(1);
                        rsp_in.is_empty = 1'b0;
                        rsp_in.is_full  = (occ_ff == CW'(DEPTH - 1));
                     end
                     rsp_valid_in = 1'b1;
                  end
                  OP_EXTRACT: begin
                     if (occ_ff == '0) begin
                        rsp_in.status = ST_EMPTY;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        // fetch entry 0; scan starts next cycle
                        idx_in   = '0;
                        rd_addr  = '0;
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_SCAN: begin
            best_idx_in = best_idx_nx;
            best_val_in = best_val_nx;
            if (at_last) begin
               // start the close-up at the winner, prefetch its successor
               idx_in   = best_idx_nx;
               rd_addr  = best_idx_nx + AW'(1);
               state_in = S_SHIFT;
            end else begin
               idx_in  = idx_ff + AW'(1);
               rd_addr = idx_ff + AW'(1);
            end
         end
         S_SHIFT: begin
            if (at_last) begin
               occ_in           = occ_dec;
               rsp_in.out_value = best_val_ff;
               rsp_in.status    = ST_OK;
               rsp_in.is_empty  = (occ_dec == '0);
               rsp_in.is_full   = 1'b0;
               rsp_valid_in     = 1'b1;
               state_in         = S_IDLE;
            end else begin
               // move entry idx+1 down to idx, prefetch idx+2
               wr_en   = 1'b1;
               wr_addr = idx_ff;
               wr_data = rd_data;
               idx_in  = idx_ff + AW'(1);
               rd_addr = idx_ff + AW'(2);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      best_idx_ff <= best_idx_in;
      best_val_ff <= best_val_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[hdl/mpq_mem.sv]
`timescale 1ns / 1ps
// Entry store of the max-priority queue: one write port, one read port,
// read data registered. Depends on mpq_pkg for the value width.
module mpq_mem #(
   parameter int DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                wr_en,
   input  logic [$clog2(DEPTH)-1:0]            wr_addr,
   input  logic signed [mpq_pkg::VALUE_W-1:0]  wr_data,
   input  logic [$clog2(DEPTH)-1:0]            rd_addr,
   output logic signed [mpq_pkg::VALUE_W-1:0]  rd_data
);
   import mpq_pkg::*;

   logic signed [VALUE_W-1:0] mem_ff [DEPTH];
   logic signed [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// Self-checking bench for max_priority_queue_core: directed and random request runs against a
// scoreboard that models the queue. Depends on mpq_pkg and the core RTL.
module testbench;
   import mpq_pkg::*;

   localparam int QUEUE_DEPTH = 16;
   localparam int ITEM_TARGET = 1350;
   localparam int DRAIN_CYCLES = 2 * QUEUE_DEPTH + 8;
   localparam int CYCLE_LIMIT = 500000;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

   class mpq_scoreboard;
      logic signed [VALUE_W-1:0] slots[QUEUE_DEPTH];
      int unsigned fill;
      rsp_type pending[$];
      int unsigned errors;

      function new();
         fill = 0;
         errors = 0;
      endfunction

      // Apply one accepted request to the queue model and queue its response.
      function void note_request(req_type word);
         rsp_type r;
         int best;
         r = '0;
         r.status = ST_OK;
         case (word.op)
            OP_CLEAR: begin
               fill = 0;
            end
            OP_INSERT: begin
               if (fill >= QUEUE_DEPTH) begin
                  r.status = ST_FULL;
               end else begin
                  slots[fill] = word.value;
                  fill++;
               end
            end
            OP_EXTRACT: begin
               if (fill == 0) begin
                  r.status = ST_EMPTY;
               end else begin
                  // strict compare keeps the oldest of equal values
                  best = 0;
                  for (int i = 1; i < fill; i++)
                     if (slots[i] > slots[best]) best = i;
                  r.out_value = slots[best];
                  for (int i = best; i + 1 < fill; i++)
                     slots[i] = slots[i + 1];
                  fill--;
               end
            end
            default: ;
         endcase
         r.is_empty = (fill == 0);
         r.is_full = (fill >= QUEUE_DEPTH);
         pending.push_back(r);
      endfunction

      task report(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_response(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            report($sformatf("response word with nothing expected (out_value %0d)",
                             got.out_value));
            return;
         end
         want = pending.pop_front();
         if (got.out_value !== want.out_value)
            report($sformatf("out_value %0d, expected %0d", got.out_value, want.out_value));
         if (got.status !== want.status)
            report($sformatf("status %0d, expected %0d", got.status, want.status));
         if (got.is_empty !== want.is_empty)
            report($sformatf("is_empty %b, expected %b", got.is_empty, want.is_empty));
         if (got.is_full !== want.is_full)
            report($sformatf("is_full %b, expected %b", got.is_full, want.is_full));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b1;
   rsp_type rsp_data;

   mpq_scoreboard sb = new();
   logic req_taken = 1'b0;
   int unsigned cycle_count = 0;
   int unsigned item_count = 0;
   int burst_left = 0;
   int stall_mode = 0;
   int stall_phase = 0;
   int stall_run = 0;

   max_priority_queue_core #(
      .DEPTH(QUEUE_DEPTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      req_taken = !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) sb.note_request(req_data);
         if (rsp_valid && rsp_ready) sb.check_response(rsp_data);
      end
   end

   // Receiver: pick a random stall pattern (none, short or long stalls) and apply it to rsp_ready.
   always @(negedge clock) begin
      if (stall_phase == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_phase = 300;
      end
      stall_phase--;
      if (stall_run > 0) begin
         rsp_ready = 1'b0;
         stall_run--;
      end else begin
         rsp_ready = 1'b1;
         case (stall_mode)
            1: if ($urandom_range(0, 2) == 0) stall_run = $urandom_range(1, 3);
            2: if ($urandom_range(0, 15) == 0) stall_run = $urandom_range(5, 20);
            default: ;
         endcase
      end
   end

   // Hold the word until taken; valid stays high into the next word of a burst.
   task automatic send_word(input logic [1:0] op, input logic signed [VALUE_W-1:0] value);
      req_data.op = op;
      req_data.value = value;
      req_valid = 1'b1;
      do @(negedge clock); while (!req_taken);
      if (op != OP_UNUSED) item_count++;
      if (burst_left == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      end else begin
         burst_left--;
      end
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return VAL_MAX;
         1: return VAL_MIN;
         2, 3: return $signed($urandom_range(0, 6)) - 3;
         default: return $urandom;
      endcase
   endfunction

   task automatic run_episode();
      int kind;
      int n_ins;
      int n_ext;
      bit mixed;
      kind = $urandom_range(0, 11);
      if (kind == 0) begin
         send_word(OP_CLEAR, $urandom);
      end else if (kind == 1) begin
         send_word(OP_UNUSED, $urandom);
      end else begin
         n_ins = $urandom_range(1, 20);
         n_ext = $urandom_range(1, 20);
         mixed = ($urandom_range(0, 2) == 0);
         while (n_ins + n_ext > 0) begin
            if (n_ins > 0 && (n_ext == 0 || !mixed || $urandom_range(0, 1) == 0)) begin
               send_word(OP_INSERT, pick_value());
               n_ins--;
            end else begin
               send_word(OP_EXTRACT, $urandom);
               n_ext--;
            end
         end
      end
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset = 1'b0;

      send_word(OP_EXTRACT, VAL_MAX);
      send_word(OP_UNUSED, VAL_MIN);
      send_word(OP_INSERT, VAL_MIN);
      send_word(OP_INSERT, VAL_MAX);
      send_word(OP_INSERT, 0);
      send_word(OP_INSERT, -1);
      send_word(OP_INSERT, VAL_MAX);
      send_word(OP_INSERT, 5);
      send_word(OP_EXTRACT, 0);
      send_word(OP_EXTRACT, -1);
      send_word(OP_UNUSED, 0);
      send_word(OP_EXTRACT, 0);
      send_word(OP_EXTRACT, 0);
      send_word(OP_EXTRACT, 0);
      send_word(OP_EXTRACT, 0);
      send_word(OP_EXTRACT, 0);
      send_word(OP_INSERT, 7);
      send_word(OP_CLEAR, -1);
      send_word(OP_EXTRACT, 0);
      // fill past the top to hit the full case
      for (int i = 0; i < QUEUE_DEPTH + 2; i++) send_word(OP_INSERT, pick_value());
      send_word(OP_EXTRACT, 0);

      while (item_count < ITEM_TARGET) run_episode();

      req_valid = 1'b0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

[sim.f]
hdl/mpq_pkg.sv
hdl/mpq_mem.sv
hdl/max_priority_queue_core.sv
sim/testbench.sv
